>>> src/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types and constants for the keyframe track sampler.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int NCOMP       = 4;
  localparam int CI_W        = 2;
  localparam int KEY_IDX_W   = 8;
  localparam int IN_TDATA_W  = KEY_IDX_W + DATA_W + NCOMP * DATA_W;
  localparam int OUT_TDATA_W = NCOMP * DATA_W;

  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_COUNT   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INTERP_MODE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_COMP_COUNT  = 2'd2;

  localparam logic [1:0] MODE_STEP = 2'd0;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

endpackage

>>> src/kts_ram.sv
// ----------------------------------------------------------------------------
// kts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/kts_div.sv
// ----------------------------------------------------------------------------
// kts_div
// Restoring divider, one quotient bit per cycle: quo = (num << 16) / den,
// for num < den.
// ----------------------------------------------------------------------------
module kts_div import kts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  output logic              done,
  output logic [FRAC_W-1:0] quo
);

  logic [DATA_W-1:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0]   den_r;
  logic [FRAC_W-1:0]   quo_r;
  logic [3:0]          cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [DATA_W:0]     sh;
  logic [DATA_W:0]     diff;
  logic                ge;

  assign sh      = {rem_r, 1'b0};
  assign diff    = sh - {1'b0, den_r};
  assign ge      = (sh >= {1'b0, den_r});
  assign rem_nxt = ge ? diff[DATA_W-1:0] : sh[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r  <= cnt_r + 4'd1;
      busy_r <= (cnt_r != 4'(FRAC_W - 1));
      done_r <= (cnt_r == 4'(FRAC_W - 1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[FRAC_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> src/kts_lerp.sv
// ----------------------------------------------------------------------------
// kts_lerp
// Lerp unit: registered (b - a) * frac, then a + floor(product / 65536).
// ----------------------------------------------------------------------------
module kts_lerp import kts_pkg::*; (
  input  logic                     clk,
  input  logic                     ld,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  input  logic [FRAC_W-1:0]        frac,
  output logic signed [DATA_W-1:0] res
);

  localparam int PW = DATA_W + FRAC_W + 2;

  logic signed [DATA_W:0]   diff;
  logic signed [FRAC_W:0]   frac_s;
  logic signed [PW-1:0]     p_nxt;
  logic signed [PW-1:0]     p_r;
  logic signed [DATA_W-1:0] a_r;
  logic [PW-FRAC_W-1:0]     sum;

  assign diff   = {b[DATA_W-1], b} - {a[DATA_W-1], a};
  assign frac_s = {1'b0, frac};
  assign p_nxt  = diff * frac_s;

  always_ff @(posedge clk) begin
    if (ld) begin
      a_r <= a;
      p_r <= p_nxt;
    end
  end

  assign sum = {{(PW-FRAC_W-DATA_W){a_r[DATA_W-1]}}, a_r} + p_r[PW-1:FRAC_W];
  assign res = sum[DATA_W-1:0];

endmodule

>>> src/keyframe_track_sampler.sv
// ----------------------------------------------------------------------------
// keyframe_track_sampler
// Keyframe table with clamped, binary-searched step or linear sampling.
// ----------------------------------------------------------------------------
// A write word (tuser 0) loads one keyframe slot as it is accepted. A sample
// word (tuser 1) runs the sequencer: one table read per search step over a
// single RAM read port, a 16-step serial fraction divide, then one shared
// multiplier pass per component. An empty table goes straight to the result,
// a clamped time answers after the first or last key read, and the divide is
// skipped in step mode or when the time is not strictly inside the key span.
// The input is not ready during a sample. The result sits in an output
// register, so the next word is taken while it waits.
module keyframe_track_sampler import kts_pkg::*; #(
  parameter int MAX_KEYS       = 256,
  parameter int MAX_COMPONENTS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // key_index, time_value, value_x, value_y, value_z, value_w
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  logic                   in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // sample_x, sample_y, sample_z, sample_w
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int KAW = $clog2(MAX_KEYS);
  localparam int NW  = (KAW + 1 > CFG_DATA_W) ? KAW + 1 : CFG_DATA_W;
  localparam int VW  = MAX_COMPONENTS * DATA_W;
  localparam int VPW = NCOMP * DATA_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RF   = 4'd1;
  localparam logic [3:0] S_CF   = 4'd2;
  localparam logic [3:0] S_RL   = 4'd3;
  localparam logic [3:0] S_CL   = 4'd4;
  localparam logic [3:0] S_SRCH = 4'd5;
  localparam logic [3:0] S_SCMP = 4'd6;
  localparam logic [3:0] S_RLO  = 4'd7;
  localparam logic [3:0] S_RHI  = 4'd8;
  localparam logic [3:0] S_GHI  = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_MUL  = 4'd11;
  localparam logic [3:0] S_ADD  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  // config
  logic [8:0] key_count_r;
  logic [1:0] interp_mode_r;
  logic [2:0] comp_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r   <= 9'd0;
      interp_mode_r <= 2'd1;
      comp_count_r  <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_KEY_COUNT:   key_count_r   <= cfg_wdata;
        CFG_INTERP_MODE: interp_mode_r <= cfg_wdata[1:0];
        CFG_COMP_COUNT:  comp_count_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic [KEY_IDX_W-1:0]     in_key_index;
  logic signed [DATA_W-1:0] in_time;
  logic [VW-1:0]            in_values;
  logic                     in_acc;

  assign in_key_index = in_tdata[KEY_IDX_W-1:0];
  assign in_time      = in_tdata[KEY_IDX_W +: DATA_W];
  assign in_values    = in_tdata[KEY_IDX_W + DATA_W +: VW];
  assign in_acc       = in_tvalid & in_tready;

  logic [NW-1:0] n_cur;
  logic [2:0]    nc_cur;

  assign n_cur  = (NW'(key_count_r) > NW'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(key_count_r);
  assign nc_cur = (comp_count_r > 3'(MAX_COMPONENTS)) ? 3'(MAX_COMPONENTS) : comp_count_r;

  // sequencer state
  logic [3:0]               state_r, state_nxt;
  logic signed [DATA_W-1:0] t_r, t_nxt;
  logic [NW-1:0]            n_r, n_nxt;
  logic [2:0]               nc_r, nc_nxt;
  logic                     step_r, step_nxt;
  logic [NW-1:0]            lo_r, lo_nxt;
  logic [NW-1:0]            hi_r, hi_nxt;
  logic [NW-1:0]            mid_r, mid_nxt;
  logic signed [DATA_W-1:0] fa_r, fa_nxt;
  logic [VPW-1:0]           va_r, va_nxt;
  logic [VPW-1:0]           vb_r, vb_nxt;
  logic [FRAC_W-1:0]        frac_r, frac_nxt;
  logic [2:0]               ci_r, ci_nxt;
  logic [DATA_W-1:0]        res_r [NCOMP];
  logic [DATA_W-1:0]        res_nxt [NCOMP];
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;

  // table
  logic                     tbl_we;
  logic [KAW-1:0]           tbl_waddr;
  logic [NW-1:0]            rd_idx;
  logic signed [DATA_W-1:0] rd_time;
  logic [VW-1:0]            rd_val;
  logic [VPW-1:0]           rd_val_pad;

  assign tbl_we    = in_acc & ~in_tuser & (32'(in_key_index) < 32'(MAX_KEYS));
  assign tbl_waddr = KAW'(in_key_index);

  kts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (in_time),
    .raddr (rd_idx[KAW-1:0]),
    .rdata (rd_time)
  );

  kts_ram #(.WIDTH(VW), .DEPTH(MAX_KEYS)) u_value_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (in_values),
    .raddr (rd_idx[KAW-1:0]),
    .rdata (rd_val)
  );

  assign rd_val_pad = VPW'(rd_val);

  // search helpers
  logic [NW:0]   mid_sum;
  logic [NW-1:0] mid_cur;
  logic          span_open;

  assign mid_sum   = (NW + 1)'(lo_r) + (NW + 1)'(hi_r);
  assign mid_cur   = mid_sum[NW:1];
  assign span_open = ((lo_r + NW'(1)) < hi_r);

  always_comb begin
    unique case (state_r)
      S_RL:    rd_idx = n_r - NW'(1);
      S_SRCH:  rd_idx = mid_cur;
      S_RLO:   rd_idx = lo_r;
      S_RHI:   rd_idx = hi_r;
      default: rd_idx = '0;
    endcase
  end

  // fraction setup
  logic signed [DATA_W:0] num_d;
  logic signed [DATA_W:0] den_d;
  div_req_t               div_req;
  logic                   div_done;
  logic [FRAC_W-1:0]      div_quo;

  assign num_d = {t_r[DATA_W-1], t_r} - {fa_r[DATA_W-1], fa_r};
  assign den_d = {rd_time[DATA_W-1], rd_time} - {fa_r[DATA_W-1], fa_r};

  always_comb begin
    div_req.start = (state_r == S_GHI) & ~step_r & (den_d > 0) & (num_d > 0)
                    & (num_d < den_d);
    div_req.num   = num_d[DATA_W-1:0];
    div_req.den   = den_d[DATA_W-1:0];
  end

  kts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  // shared lerp unit
  logic                     lerp_ld;
  logic signed [DATA_W-1:0] lerp_res;

  assign lerp_ld = (state_r == S_MUL) & (ci_r < nc_r);

  kts_lerp u_lerp (
    .clk  (clk),
    .ld   (lerp_ld),
    .a    (va_r[ci_r[CI_W-1:0] * DATA_W +: DATA_W]),
    .b    (vb_r[ci_r[CI_W-1:0] * DATA_W +: DATA_W]),
    .frac (frac_r),
    .res  (lerp_res)
  );

  logic out_free;
  assign out_free = ~out_valid_r | out_tready;

  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    n_nxt     = n_r;
    nc_nxt    = nc_r;
    step_nxt  = step_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    fa_nxt    = fa_r;
    va_nxt    = va_r;
    vb_nxt    = vb_r;
    frac_nxt  = frac_r;
    ci_nxt    = ci_r;
    for (int i = 0; i < NCOMP; i++) begin
      res_nxt[i] = res_r[i];
    end
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser) begin
          t_nxt    = in_time;
          n_nxt    = n_cur;
          nc_nxt   = nc_cur;
          step_nxt = (interp_mode_r == MODE_STEP);
          ci_nxt   = '0;
          for (int i = 0; i < NCOMP; i++) begin
            res_nxt[i] = '0;
          end
          state_nxt = (n_cur == '0) ? S_DONE : S_RF;
        end
      end
      S_RF: state_nxt = S_CF;
      S_CF: begin
        if (n_r == NW'(1) || t_r <= rd_time) begin
          for (int i = 0; i < NCOMP; i++) begin
            res_nxt[i] = (3'(i) < nc_r) ? rd_val_pad[i*DATA_W +: DATA_W] : '0;
          end
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RL;
        end
      end
      S_RL: state_nxt = S_CL;
      S_CL: begin
        if (t_r >= rd_time) begin
          for (int i = 0; i < NCOMP; i++) begin
            res_nxt[i] = (3'(i) < nc_r) ? rd_val_pad[i*DATA_W +: DATA_W] : '0;
          end
          state_nxt = S_DONE;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = n_r - NW'(1);
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (span_open) begin
          mid_nxt   = mid_cur;
          state_nxt = S_SCMP;
        end else begin
          state_nxt = S_RLO;
        end
      end
      S_SCMP: begin
        if (rd_time <= t_r) begin
          lo_nxt = mid_r;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_SRCH;
      end
      S_RLO: state_nxt = S_RHI;
      S_RHI: begin
        fa_nxt    = rd_time;
        va_nxt    = rd_val_pad;
        state_nxt = S_GHI;
      end
      S_GHI: begin
        vb_nxt = rd_val_pad;
        ci_nxt = '0;
        if (div_req.start) begin
          state_nxt = S_DIV;
        end else begin
          frac_nxt  = (!step_r && den_d > 0 && num_d > 0) ? '1 : '0;
          state_nxt = S_MUL;
        end
      end
      S_DIV: begin
        if (div_done) begin
          frac_nxt  = div_quo;
          state_nxt = S_MUL;
        end
      end
      S_MUL: state_nxt = (ci_r < nc_r) ? S_ADD : S_DONE;
      S_ADD: begin
        res_nxt[ci_r[CI_W-1:0]] = lerp_res;
        ci_nxt                  = ci_r + 3'd1;
        state_nxt               = S_MUL;
      end
      S_DONE: begin
        if (out_free) begin
          out_data_nxt  = {res_r[3], res_r[2], res_r[1], res_r[0]};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ci_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ci_r        <= ci_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    n_r        <= n_nxt;
    nc_r       <= nc_nxt;
    step_r     <= step_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    fa_r       <= fa_nxt;
    va_r       <= va_nxt;
    vb_r       <= vb_nxt;
    frac_r     <= frac_nxt;
    out_data_r <= out_data_nxt;
    for (int i = 0; i < NCOMP; i++) begin
      res_r[i] <= res_nxt[i];
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> src/kts_checker.sv
// ----------------------------------------------------------------------------
// kts_checker
// Port-level checks for the keyframe track sampler, bound to the top level.
// ----------------------------------------------------------------------------
module kts_checker import kts_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input ready right after a sample word");

  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> in_tready)
    else $error("write word did not complete in one cycle");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result issued while sequencer busy");

endmodule

bind keyframe_track_sampler kts_checker u_kts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> dv/tb_keyframe_track_sampler.sv
// ----------------------------------------------------------------------------
// tb_keyframe_track_sampler
// Self-checking bench for the keyframe track sampler.
// ----------------------------------------------------------------------------
// Loads keyframe tables over the input stream, then samples them. A short
// hand-picked sequence hits the empty table, the one-key table, both clamps,
// duplicate key times, full-range lerps, every mode and component counts 0, 1, 4 and 7.
// Random table setups follow with sorted, wide, duplicated and unsorted key
// times. Every accepted word runs through a local track model and each sample
// word is compared field by field, under phases of input and output throttling.
// ----------------------------------------------------------------------------
module tb_keyframe_track_sampler;
  timeunit 1ns;
  timeprecision 1ps;

  import kts_pkg::*;

  localparam logic       REQ_WRITE       = 1'b0;
  localparam logic       REQ_SAMPLE      = 1'b1;
  localparam logic [1:0] MODE_LINEAR     = 2'd1;
  localparam logic [1:0] MODE_CUBIC      = 2'd2;
  localparam logic [1:0] MODE_LINEAR_ALT = 2'd3;
  localparam int         TABLE_DEPTH     = 256;
  localparam int         WORD_TARGET     = 1350;
  localparam logic [31:0] Q_MIN          = 32'h8000_0000;
  localparam logic [31:0] Q_MAX          = 32'h7fff_ffff;

  typedef struct packed {
    logic [NCOMP-1:0][DATA_W-1:0] val;
    logic [DATA_W-1:0]            tm;
    logic [KEY_IDX_W-1:0]         slot;
  } key_word_t;

  class track_predictor;
    int          key_tm  [TABLE_DEPTH];
    int          key_val [TABLE_DEPTH][NCOMP];
    int unsigned key_count = 0;
    int unsigned mode      = MODE_LINEAR;
    int unsigned comps     = NCOMP;
    logic [OUT_TDATA_W-1:0] expected_samples[$];
    int    errors  = 0;
    int    checked = 0;
    string comp_name [NCOMP] = '{"sample_x", "sample_y", "sample_z", "sample_w"};

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        CFG_KEY_COUNT:   key_count = 32'(data);
        CFG_INTERP_MODE: mode      = 32'(data[1:0]);
        CFG_COMP_COUNT:  comps     = 32'(data[2:0]);
        default: ;
      endcase
    endfunction

    function void note_word(logic req, key_word_t w);
      int unsigned n, nc, lo, hi, mid, c;
      int          tm;
      longint      fa, fb, num, den, frac, a, b;
      longint      res [NCOMP];
      logic [OUT_TDATA_W-1:0] sample;
      tm = w.tm;
      if (req == REQ_WRITE) begin
        key_tm[w.slot] = w.tm;
        for (c = 0; c < NCOMP; c++) key_val[w.slot][c] = w.val[c];
        return;
      end
      for (c = 0; c < NCOMP; c++) res[c] = 0;
      n  = (key_count > TABLE_DEPTH) ? TABLE_DEPTH : key_count;
      nc = (comps > NCOMP) ? NCOMP : comps;
      if (n == 0) begin
      end else if (n == 1 || tm <= key_tm[0]) begin
        for (c = 0; c < nc; c++) res[c] = key_val[0][c];
      end else if (tm >= key_tm[n-1]) begin
        for (c = 0; c < nc; c++) res[c] = key_val[n-1][c];
      end else begin
        lo = 0;
        hi = n - 1;
        while (lo + 1 < hi) begin
          mid = (lo + hi) / 2;
          if (key_tm[mid] <= tm) lo = mid;
          else hi = mid;
        end
        hi   = lo + 1;
        fa   = key_tm[lo];
        fb   = key_tm[hi];
        frac = 0;
        if (fb > fa) begin
          num = tm - fa;
          den = fb - fa;
          if (num > 0) begin
            frac = (num >= den) ? 65535 : (num * 65536) / den;
            if (frac > 65535) frac = 65535;
          end
        end
        for (c = 0; c < nc; c++) begin
          a = key_val[lo][c];
          b = key_val[hi][c];
          res[c] = (mode == MODE_STEP) ? a : a + (((b - a) * frac) >>> 16);
        end
      end
      for (c = 0; c < NCOMP; c++) sample[c*DATA_W +: DATA_W] = res[c][DATA_W-1:0];
      expected_samples.push_back(sample);
    endfunction

    function void check_sample(logic [OUT_TDATA_W-1:0] got);
      logic [OUT_TDATA_W-1:0] want;
      int c;
      if (expected_samples.size() == 0) begin
        $error("sample word %h with nothing pending", got);
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      checked++;
      for (c = 0; c < NCOMP; c++) begin
        if (got[c*DATA_W +: DATA_W] !== want[c*DATA_W +: DATA_W]) begin
          $error("%s: expected %0d, got %0d", comp_name[c],
                 $signed(want[c*DATA_W +: DATA_W]), $signed(got[c*DATA_W +: DATA_W]));
          errors++;
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  track_predictor tracker = new;
  int plan_tm [TABLE_DEPTH];
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int words_sent    = 0;
  int setups        = 0;

  keyframe_track_sampler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  // result side: check on the edge, throttle on the falling edge
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) tracker.check_sample(out_tdata);
      @(negedge clk);
      out_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [31:0] clamp_q(longint v);
    if (v > 64'sd2147483647) return Q_MAX;
    if (v < -64'sd2147483648) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic logic [31:0] rand_q();
    case ($urandom_range(9))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic key_word_t rand_word();
    key_word_t w;
    int c;
    w.slot = KEY_IDX_W'($urandom);
    w.tm   = rand_q();
    for (c = 0; c < NCOMP; c++) w.val[c] = rand_q();
    return w;
  endfunction

  function automatic key_word_t key_word(logic [7:0] slot, logic [31:0] tm, logic [31:0] x,
                                         logic [31:0] y, logic [31:0] z, logic [31:0] w);
    key_word_t k;
    k.slot = slot;
    k.tm   = tm;
    k.val  = {w, z, y, x};
    return k;
  endfunction

  function automatic logic [31:0] rand_between(longint a, longint b);
    longint span;
    if (b < a) begin
      span = a;
      a    = b;
      b    = span;
    end
    span = b - a + 1;
    return clamp_q(a + longint'({$urandom, $urandom} >> 1) % span);
  endfunction

  function automatic logic [31:0] pick_time(int n);
    int i;
    if (n == 0) return $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        if (n < 2) return $urandom;
        i = $urandom_range(0, n - 2);
        return rand_between(plan_tm[i], plan_tm[i+1]);
      end
      4, 5: begin
        i = $urandom_range(0, n - 1);
        return clamp_q(longint'(plan_tm[i]) + $urandom_range(0, 2) - 1);
      end
      6: return $urandom;
      7: return $urandom_range(1) ? Q_MIN : Q_MAX;
      default: return rand_between(longint'(plan_tm[0]) - 131072,
                                   longint'(plan_tm[n-1]) + 131072);
    endcase
  endfunction

  task automatic send_word(logic req, key_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = w;
    do @(posedge clk); while (!in_tready);
    tracker.note_word(req, w);
    words_sent++;
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, int data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = CFG_DATA_W'(data);
    tracker.write_reg(addr, CFG_DATA_W'(data));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // drain all samples, then give a trailing table write time to land
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.expected_samples.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(int kc, int mode, int cc);
    settle();
    write_reg(CFG_KEY_COUNT, kc);
    write_reg(CFG_INTERP_MODE, mode);
    write_reg(CFG_COMP_COUNT, cc);
  endtask

  task automatic sample_at(logic [31:0] tm);
    key_word_t w;
    w    = rand_word();
    w.tm = tm;
    send_word(REQ_SAMPLE, w);
  endtask

  task automatic load_table(int n);
    int        i, style;
    longint    base, tl;
    key_word_t w;
    style = $urandom_range(19);
    base  = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
    for (i = 0; i < n; i++) begin
      if (style < 10) begin
        tl = base;
        base += ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3 * 65536);
      end else if (style < 14) begin
        tl = -64'sd2147483648 + (longint'(i) * 64'sd4294967295) / n + $urandom_range(0, 255);
      end else if (style < 17) begin
        tl = int'($urandom);
      end else begin
        tl = base;
        base += $urandom_range(0, 1) * 65536;
      end
      plan_tm[i] = clamp_q(tl);
      w      = rand_word();
      w.slot = KEY_IDX_W'(i);
      w.tm   = plan_tm[i];
      send_word(REQ_WRITE, w);
      if (n < TABLE_DEPTH && $urandom_range(9) == 0) begin
        w      = rand_word();
        w.slot = KEY_IDX_W'($urandom_range(n, TABLE_DEPTH - 1));
        send_word(REQ_WRITE, w);
      end
    end
  endtask

  task automatic run_setup(int kc, int mode, int cc);
    int        n, count, i, r;
    key_word_t w;
    configure(kc, mode, cc);
    n = (kc > TABLE_DEPTH) ? TABLE_DEPTH : kc;
    load_table(n);
    count = $urandom_range(15, 40);
    for (i = 0; i < count; i++) begin
      w = rand_word();
      r = $urandom_range(19);
      if (r == 0 && n > 0) begin
        // fresh values, same key time
        w.slot = KEY_IDX_W'($urandom_range(0, n - 1));
        w.tm   = plan_tm[w.slot];
        send_word(REQ_WRITE, w);
      end else if (r == 1 && n < TABLE_DEPTH) begin
        w.slot = KEY_IDX_W'($urandom_range(n, TABLE_DEPTH - 1));
        send_word(REQ_WRITE, w);
      end else begin
        w.tm = pick_time(n);
        send_word(REQ_SAMPLE, w);
      end
    end
  endtask

  initial begin : main
    int kc, cc;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = REQ_WRITE;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_KEY_COUNT;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table straight out of reset
    sample_at(Q_MAX);
    send_word(REQ_WRITE, key_word(8'hff, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_word(REQ_WRITE, key_word(8'd0, 32'hffff_0000, Q_MAX, Q_MIN, 32'h0, 32'hffff_ffff));
    send_word(REQ_WRITE, key_word(8'd1, 32'h0, Q_MIN, Q_MAX, 32'h0001_0000, 32'h1));
    send_word(REQ_WRITE, key_word(8'd2, 32'h0001_0000, Q_MAX, Q_MIN, 32'h0003_8000,
                                  32'hffff_0000));
    // duplicate key time
    send_word(REQ_WRITE, key_word(8'd3, 32'h0001_0000, 32'h0, 32'h0, Q_MAX, Q_MIN));
    send_word(REQ_WRITE, key_word(8'd4, Q_MAX, 32'h1234_5678, 32'hedcb_a988, 32'h1, Q_MAX));

    configure(1, MODE_LINEAR, NCOMP);
    sample_at(Q_MAX);
    configure(5, MODE_LINEAR, NCOMP);
    sample_at(Q_MIN);
    sample_at(32'hffff_0000);
    sample_at(32'hffff_8000);
    sample_at(32'h0000_0001);
    sample_at(32'h0001_0000);
    sample_at(32'h7fff_fffe);
    sample_at(Q_MAX);
    configure(5, MODE_STEP, NCOMP);
    sample_at(32'hffff_8000);
    configure(5, MODE_CUBIC, NCOMP);
    sample_at(32'hffff_8000);
    configure(5, MODE_LINEAR_ALT, 7);
    sample_at(32'hffff_8000);
    configure(5, MODE_LINEAR, 0);
    sample_at(32'hffff_8000);
    configure(5, MODE_LINEAR, 1);
    sample_at(32'hffff_8000);

    while (words_sent < WORD_TARGET) begin
      case (setups % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      case ($urandom_range(19))
        0: kc = 0;
        1: kc = TABLE_DEPTH;
        2: kc = $urandom_range(TABLE_DEPTH + 1, 511);
        3: kc = $urandom_range(17, TABLE_DEPTH - 1);
        default: kc = $urandom_range(1, 16);
      endcase
      if (setups == 0) kc = 511;
      cc = ($urandom_range(3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, NCOMP);
      run_setup(kc, $urandom_range(0, 3), cc);
      setups++;
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.expected_samples.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("summary: %0d words over %0d random table setups, %0d samples checked",
             words_sent, setups, tracker.checked);
    $display("summary: %0d mismatches or unexpected sample words", tracker.errors);
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
src/kts_pkg.sv
src/kts_ram.sv
src/kts_div.sv
src/kts_lerp.sv
src/keyframe_track_sampler.sv
src/kts_checker.sv
dv/tb_keyframe_track_sampler.sv
